>>> hw/rtl/lbgc_pkg.sv
// Shared types, constants and the quarter-wave sine table for the beam-to-cell block.
package lbgc_pkg;

  localparam int GRID_SIZE_DEF  = 1024;
  localparam int ANGLE_BITS_DEF = 16;
  localparam int MM_PER_M       = 1000;
  localparam int QUEUE_DEPTH    = 4;
  localparam int CELL_W         = 10;

  // floor(n / 1000) == (n * DIV1000_RECIP) >> DIV1000_SHIFT for n < 2^32 / 704
  localparam logic [22:0] DIV1000_RECIP = 23'd4294968;
  localparam int          DIV1000_SHIFT = 32;

  localparam logic [7:0]  CPM_RST       = 8'd20;
  localparam logic [15:0] MAX_RANGE_RST = 16'd8000;

  localparam logic [14:0] SINE_TAB [17] = '{
    15'd0,     15'd1606,  15'd3196,  15'd4756,  15'd6270,  15'd7723,
    15'd9102,  15'd10394, 15'd11585, 15'd12665, 15'd13623, 15'd14449,
    15'd15137, 15'd15679, 15'd16069, 15'd16305, 15'd16384
  };
  localparam logic [14:0] Q14_ONE = 15'd16384;

  typedef enum logic [1:0] {
    ST_MARK    = 2'd0,
    ST_RANGE   = 2'd1,
    ST_OUTSIDE = 2'd2
  } lbgc_status_t;

  typedef enum logic {
    REG_CPM       = 1'b0,
    REG_MAX_RANGE = 1'b1
  } lbgc_reg_t;

  typedef enum logic {
    FUNC_ROBOT = 1'b0,
    FUNC_BEAM  = 1'b1
  } lbgc_func_t;

  typedef struct packed {
    logic [7:0]  cpm;
    logic [15:0] max_range;
  } lbgc_cfg_t;

  // classified item as it waits in the queue
  typedef struct packed {
    logic               reject;
    logic               is_robot;
    logic [15:0]        range_mm;
    logic signed [15:0] cos_q14;
    logic signed [15:0] sin_q14;
    logic signed [20:0] pose_x;
    logic signed [20:0] pose_y;
  } lbgc_job_t;

endpackage

>>> hw/rtl/lbgc_in_if.sv
// Input channel: beam or robot-mark item with the robot pose.
interface lbgc_in_if import lbgc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               func;
  logic [15:0]        range_mm;
  logic signed [15:0] bearing;
  logic signed [20:0] pose_x_mm;
  logic signed [20:0] pose_y_mm;
  logic signed [15:0] pose_heading;

  modport source (output valid, func, range_mm, bearing, pose_x_mm, pose_y_mm, pose_heading,
                  input ready);
  modport sink   (input valid, func, range_mm, bearing, pose_x_mm, pose_y_mm, pose_heading,
                  output ready);
endinterface

>>> hw/rtl/lbgc_out_if.sv
// Result channel: grid cell, mark kind and status.
interface lbgc_out_if import lbgc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CELL_W-1:0] cell_x;
  logic [CELL_W-1:0] cell_y;
  logic              is_robot;
  logic [1:0]        status;

  modport source (output valid, cell_x, cell_y, is_robot, status, input ready);
  modport sink   (input valid, cell_x, cell_y, is_robot, status, output ready);
endinterface

>>> hw/rtl/lbgc_cfg.sv
// APB register file: grid scale and maximum beam range.
module lbgc_cfg import lbgc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output lbgc_cfg_t   cfg
);

  logic [7:0]  cpm_r;
  logic [15:0] max_range_r;
  logic        wr_en;
  lbgc_reg_t   sel;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign sel    = lbgc_reg_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cpm_r       <= CPM_RST;
      max_range_r <= MAX_RANGE_RST;
    end else if (wr_en) begin
      unique case (sel)
        REG_CPM:       cpm_r       <= pwdata[7:0];
        REG_MAX_RANGE: max_range_r <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (sel)
      REG_CPM:       prdata = {24'd0, cpm_r};
      REG_MAX_RANGE: prdata = {16'd0, max_range_r};
      default:       prdata = '0;
    endcase
  end

  assign cfg.cpm       = cpm_r;
  assign cfg.max_range = max_range_r;

endmodule

>>> hw/rtl/lbgc_front.sv
// Front end: range check, beam angle and sine/cosine lookup, hands a job to the queue.
module lbgc_front import lbgc_pkg::*; #(
  parameter int ANGLE_BITS = ANGLE_BITS_DEF
) (
  lbgc_in_if.sink   in_ch,
  input  lbgc_cfg_t cfg,
  input  logic      push_ready,
  output logic      push_valid,
  output lbgc_job_t push_job
);

  localparam int AW = ANGLE_BITS;
  localparam int FB = AW - 6;
  localparam logic [AW-1:0] QTR_TURN = AW'(1) << (AW - 2);
  localparam logic [AW-2:0] QTR_P    = (AW-1)'(1) << (AW - 2);
  localparam logic [FB+15:0] HALF_LSB = (FB+16)'(1) << (FB - 1);

  logic [15:0]   a16;
  logic [AW-1:0] ang;
  logic [AW-1:0] ang_c;
  logic          is_beam;

  // sine in Q14, linear interpolation between table points
  function automatic logic signed [15:0] sine_q14(input logic [AW-1:0] a);
    logic [1:0]     q;
    logic [AW-2:0]  p;
    logic [4:0]     idx;
    logic [FB-1:0]  frac;
    logic [14:0]    base;
    logic [14:0]    d;
    logic [FB+15:0] t;
    logic [14:0]    mag;
    q = a[AW-1:AW-2];
    p = {1'b0, a[AW-3:0]};
    if (q[0]) p = QTR_P - p;
    idx  = p[AW-2:AW-6];
    frac = p[FB-1:0];
    if (idx >= 5'd16) begin
      mag = Q14_ONE;
    end else begin
      base = SINE_TAB[idx];
      d    = SINE_TAB[5'(idx + 5'd1)] - base;
      t    = (FB+16)'(d) * (FB+16)'(frac) + HALF_LSB;
      mag  = base + 15'(t >> FB);
    end
    return q[1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  endfunction

  assign a16 = 16'(in_ch.bearing + in_ch.pose_heading);

  if (AW >= 16) begin : g_ang_up
    assign ang = AW'(a16) << (AW - 16);
  end else begin : g_ang_dn
    assign ang = a16[15 -: AW];
  end

  assign ang_c   = ang + QTR_TURN;
  assign is_beam = (lbgc_func_t'(in_ch.func) == FUNC_BEAM);

  always_comb begin
    push_job.reject   = is_beam && (in_ch.range_mm >= cfg.max_range);
    push_job.is_robot = !is_beam;
    // a robot mark projects the pose itself: zero range gives zero offset
    push_job.range_mm = is_beam ? in_ch.range_mm : 16'd0;
    push_job.cos_q14  = sine_q14(ang_c);
    push_job.sin_q14  = sine_q14(ang);
    push_job.pose_x   = in_ch.pose_x_mm;
    push_job.pose_y   = in_ch.pose_y_mm;
  end

  assign push_valid  = in_ch.valid;
  assign in_ch.ready = push_ready;

endmodule

>>> hw/rtl/lbgc_queue.sv
// Short FIFO of classified jobs between front end and back end.
module lbgc_queue import lbgc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push_valid,
  output logic      push_ready,
  input  lbgc_job_t push_job,
  output logic      pop_valid,
  input  logic      pop_ready,
  output lbgc_job_t pop_job
);

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  lbgc_job_t     mem_r [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] cnt_r;
  logic          push, pop;

  assign push_ready = (cnt_r != CW'(QUEUE_DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_job    = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= (wr_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= (rd_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      if (push && !pop)      cnt_r <= cnt_r + 1'b1;
      else if (pop && !push) cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_job;
  end

endmodule

>>> hw/rtl/lbgc_back.sv
// Back end: beam offset, world point, grid scaling, bounds check and cell divide.
module lbgc_back import lbgc_pkg::*; #(
  parameter int GRID_SIZE = GRID_SIZE_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  lbgc_cfg_t  cfg,
  input  logic       job_valid,
  output logic       job_pop,
  input  lbgc_job_t  job,
  lbgc_out_if.source out_ch
);

  localparam int NW = $clog2(GRID_SIZE * MM_PER_M);
  localparam logic signed [33:0] NUM_HI = 34'(GRID_SIZE * MM_PER_M);
  localparam logic signed [33:0] NUM_LO = -(34'(MM_PER_M));
  localparam logic signed [33:0] CENTRE = 34'((GRID_SIZE / 2) * MM_PER_M);

  logic en;

  // stage 1: offsets
  logic               v1_r, rej1_r, rob1_r;
  logic signed [17:0] off_x_r, off_y_r;
  logic signed [20:0] pose_x1_r, pose_y1_r;
  logic signed [17:0] off_x_nxt, off_y_nxt;
  // stage 2: world point, y negated
  logic               v2_r, rej2_r, rob2_r;
  logic signed [22:0] wx_r, ny_r;
  logic signed [22:0] wy_nxt;
  // stage 3: scaled
  logic               v3_r, rej3_r, rob3_r;
  logic signed [31:0] px_r, py_r;
  logic signed [8:0]  cpm_s;
  // stage 4: bounds and dividend
  logic               v4_r, rob4_r;
  lbgc_status_t       st4_r, st4_nxt;
  logic [NW-1:0]      nx_r, ny4_r, nx_nxt, ny4_nxt;
  logic signed [33:0] num_x, num_y;
  // output register
  logic               out_vld_r;
  logic [CELL_W-1:0]  cell_x_r, cell_y_r;
  logic               rob_o_r;
  lbgc_status_t       st_o_r;
  logic [44:0]        qx, qy;

  function automatic logic signed [17:0] beam_off(input logic [15:0] r,
                                                 input logic signed [15:0] trig);
    logic [14:0] mag;
    logic [30:0] prod;
    logic [16:0] o;
    mag  = trig[15] ? 15'(-trig) : 15'(trig);
    prod = 31'(r) * 31'(mag) + 31'(Q14_ONE >> 1);
    o    = prod[30:14];
    return trig[15] ? -$signed({1'b0, o}) : $signed({1'b0, o});
  endfunction

  // whole pipe advances together; a bubble moves like an item
  assign en      = !out_vld_r || out_ch.ready;
  assign job_pop = en;

  assign off_x_nxt = beam_off(job.range_mm, job.cos_q14);
  assign off_y_nxt = beam_off(job.range_mm, job.sin_q14);
  assign wy_nxt    = 23'(pose_y1_r) + 23'(off_y_r);
  assign cpm_s     = $signed({1'b0, cfg.cpm});
  assign num_x     = 34'(px_r) + CENTRE;
  assign num_y     = 34'(py_r) + CENTRE;

  always_comb begin
    nx_nxt  = '0;
    ny4_nxt = '0;
    if (rej3_r) begin
      st4_nxt = ST_RANGE;
    end else if (num_x <= NUM_LO || num_x >= NUM_HI || num_y <= NUM_LO || num_y >= NUM_HI) begin
      st4_nxt = ST_OUTSIDE;
    end else begin
      st4_nxt = ST_MARK;
      // small negative values truncate to column zero
      if (!num_x[33]) nx_nxt  = num_x[NW-1:0];
      if (!num_y[33]) ny4_nxt = num_y[NW-1:0];
    end
  end

  assign qx = 45'(nx_r) * 45'(DIV1000_RECIP);
  assign qy = 45'(ny4_r) * 45'(DIV1000_RECIP);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r      <= 1'b0;
      v2_r      <= 1'b0;
      v3_r      <= 1'b0;
      v4_r      <= 1'b0;
      out_vld_r <= 1'b0;
    end else if (en) begin
      v1_r      <= job_valid;
      v2_r      <= v1_r;
      v3_r      <= v2_r;
      v4_r      <= v3_r;
      out_vld_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rej1_r    <= job.reject;
      rob1_r    <= job.is_robot;
      off_x_r   <= off_x_nxt;
      off_y_r   <= off_y_nxt;
      pose_x1_r <= job.pose_x;
      pose_y1_r <= job.pose_y;

      rej2_r <= rej1_r;
      rob2_r <= rob1_r;
      wx_r   <= 23'(pose_x1_r) + 23'(off_x_r);
      ny_r   <= -wy_nxt;

      rej3_r <= rej2_r;
      rob3_r <= rob2_r;
      px_r   <= 32'(wx_r) * 32'(cpm_s);
      py_r   <= 32'(ny_r) * 32'(cpm_s);

      rob4_r <= rob3_r;
      st4_r  <= st4_nxt;
      nx_r   <= nx_nxt;
      ny4_r  <= ny4_nxt;

      rob_o_r  <= rob4_r;
      st_o_r   <= st4_r;
      cell_x_r <= qx[DIV1000_SHIFT +: CELL_W];
      cell_y_r <= qy[DIV1000_SHIFT +: CELL_W];
    end
  end

  assign out_ch.valid    = out_vld_r;
  assign out_ch.cell_x   = cell_x_r;
  assign out_ch.cell_y   = cell_y_r;
  assign out_ch.is_robot = rob_o_r;
  assign out_ch.status   = st_o_r;

endmodule

>>> hw/rtl/laser_beam_to_grid_cell.sv
// Top level: laser beam / robot mark to occupancy grid cell projection.
// One item per clock sustained while the output is not stalled, one result per item.
// A result passes from its accepted item through the four-entry job queue, then four
// back-end stages (beam offset multiply, world add, scale multiply, bounds check) and
// the output register, which holds the divide-by-1000 multiply. While
// the output is stalled the back end holds and the queue absorbs up to four more items.
// No clearing pass after reset. Registers: cells_per_meter at 0x0, max_range_mm at 0x4.
module laser_beam_to_grid_cell import lbgc_pkg::*; #(
  parameter int GRID_SIZE  = GRID_SIZE_DEF,
  parameter int ANGLE_BITS = ANGLE_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  lbgc_in_if.sink     in_ch,
  lbgc_out_if.source  out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  lbgc_cfg_t cfg;
  logic      push_valid, push_ready, pop_valid, pop_ready;
  lbgc_job_t push_job, pop_job;

  lbgc_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  lbgc_front #(.ANGLE_BITS(ANGLE_BITS)) u_front (
    .in_ch      (in_ch),
    .cfg        (cfg),
    .push_ready (push_ready),
    .push_valid (push_valid),
    .push_job   (push_job)
  );

  lbgc_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_job   (push_job),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_job    (pop_job)
  );

  lbgc_back #(.GRID_SIZE(GRID_SIZE)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .job_valid (pop_valid),
    .job_pop   (pop_ready),
    .job       (pop_job),
    .out_ch    (out_ch)
  );

endmodule

>>> hw/rtl/lbgc_checker.sv
// Port-level checks on the result channel, bound to the top level.
module lbgc_checker import lbgc_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_ready,
  input logic [CELL_W-1:0] cell_x,
  input logic [CELL_W-1:0] cell_y,
  input logic              is_robot,
  input logic [1:0]        status
);

  a_rst_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable({cell_x, cell_y, is_robot, status}))
    else $error("stalled result changed");

  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && status != ST_MARK |-> cell_x == '0 && cell_y == '0)
    else $error("unmarked result carries a cell");

  a_range_beam: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && status == ST_RANGE |-> !is_robot)
    else $error("range reject on a robot mark");

endmodule

bind laser_beam_to_grid_cell lbgc_checker u_lbgc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .cell_x    (out_ch.cell_x),
  .cell_y    (out_ch.cell_y),
  .is_robot  (out_ch.is_robot),
  .status    (out_ch.status)
);
